FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Used by the top level; needs clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/dpor_pkg.sv
// Package for the DDA polygon outline rasterizer.
// Constants, op codes, state type and controller/datapath interface structs.
`timescale 1ns / 1ps
package dpor_pkg;

  localparam int COORD_BITS = 6;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_W    = 24;
  localparam int NUM_W      = COORD_BITS + FRAC_BITS;
  localparam int ACC_W      = NUM_W + 2;
  localparam int CNT_W      = $clog2(NUM_W + 1);

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_CLOSE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DRAW
  } state_t;

  typedef struct packed {
    logic load_first;
    logic load_prev;
    logic line_start;
    logic to_first;
    logic div_step;
    logic div_finish;
    logic pixel_step;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic div_done;
    logic last;
  } status_t;

endpackage

FILE: rtl/dpor_datapath.sv
// Datapath: vertex store, line setup, two-lane restoring divider, DDA accumulators.
// Depends on dpor_pkg.
`timescale 1ns / 1ps
module dpor_datapath (
  input  logic                            clk,
  input  dpor_pkg::cmd_t                  cmd,
  input  logic [dpor_pkg::COORD_BITS-1:0] vertex_x,
  input  logic [dpor_pkg::COORD_BITS-1:0] vertex_y,
  output dpor_pkg::status_t               status,
  output logic [dpor_pkg::COORD_BITS-1:0] pixel_x,
  output logic [dpor_pkg::COORD_BITS-1:0] pixel_y
);
  import dpor_pkg::*;

  logic [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic [COORD_BITS-1:0] len, pix_cnt;
  logic [COORD_BITS-1:0] rem_x, rem_y;
  logic [NUM_W-1:0]      quo_x, quo_y;
  logic [CNT_W-1:0]      step_cnt;
  logic                  neg_x, neg_y;
  logic [ACC_W-1:0]      inc_x, inc_y, acc_x, acc_y;

  logic [COORD_BITS-1:0] tgt_x, tgt_y, adx, ady, line_len;
  logic [COORD_BITS:0]   dx, dy, ndx, ndy;
  logic [COORD_BITS:0]   rem7_x, rem7_y, diff_x, diff_y, len7;
  logic                  ge_x, ge_y;
  logic [ACC_W-1:0]      qext_x, qext_y;

  always_comb begin
    tgt_x = cmd.to_first ? (cmd.load_first ? vertex_x : first_x) : prev_x;
    tgt_y = cmd.to_first ? (cmd.load_first ? vertex_y : first_y) : prev_y;
    dx  = {1'b0, tgt_x} - {1'b0, vertex_x};
    dy  = {1'b0, tgt_y} - {1'b0, vertex_y};
    ndx = ~dx + 1'b1;
    ndy = ~dy + 1'b1;
    adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    line_len = (adx >= ady) ? adx : ady;

    len7   = {1'b0, len};
    rem7_x = {rem_x, quo_x[NUM_W-1]};
    rem7_y = {rem_y, quo_y[NUM_W-1]};
    ge_x   = rem7_x >= len7;
    ge_y   = rem7_y >= len7;
    diff_x = rem7_x - len7;
    diff_y = rem7_y - len7;

    qext_x = {2'b00, quo_x};
    qext_y = {2'b00, quo_y};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      first_x <= vertex_x;
      first_y <= vertex_y;
    end
    if (cmd.load_prev) begin
      prev_x <= vertex_x;
      prev_y <= vertex_y;
    end
    if (cmd.line_start) begin
      len      <= line_len;
      neg_x    <= dx[COORD_BITS];
      neg_y    <= dy[COORD_BITS];
      quo_x    <= {adx, {FRAC_BITS{1'b0}}};
      quo_y    <= {ady, {FRAC_BITS{1'b0}}};
      rem_x    <= '0;
      rem_y    <= '0;
      step_cnt <= '0;
      acc_x    <= {2'b00, vertex_x, {FRAC_BITS{1'b0}}};
      acc_y    <= {2'b00, vertex_y, {FRAC_BITS{1'b0}}};
      pix_cnt  <= '0;
    end else begin
      if (cmd.div_step) begin
        rem_x    <= ge_x ? diff_x[COORD_BITS-1:0] : rem7_x[COORD_BITS-1:0];
        rem_y    <= ge_y ? diff_y[COORD_BITS-1:0] : rem7_y[COORD_BITS-1:0];
        quo_x    <= {quo_x[NUM_W-2:0], ge_x};
        quo_y    <= {quo_y[NUM_W-2:0], ge_y};
        step_cnt <= step_cnt + 1'b1;
      end
      if (cmd.pixel_step) begin
        acc_x   <= acc_x + inc_x;
        acc_y   <= acc_y + inc_y;
        pix_cnt <= pix_cnt + 1'b1;
      end
    end
    if (cmd.div_finish) begin
      inc_x <= neg_x ? (~qext_x + 1'b1) : qext_x;
      inc_y <= neg_y ? (~qext_y + 1'b1) : qext_y;
    end
  end

  // negative positions clamp to zero
  assign pixel_x = acc_x[ACC_W-1] ? '0 : acc_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  assign pixel_y = acc_y[ACC_W-1] ? '0 : acc_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];

  assign status.len_zero = (len == '0);
  assign status.div_done = (step_cnt == CNT_W'(NUM_W));
  assign status.last     = (pix_cnt == len - 1'b1);

endmodule

FILE: rtl/dpor_ctrl.sv
// Controller: polygon state (has_vertex, accepting) and the line sequencer FSM.
// Depends on dpor_pkg.
`timescale 1ns / 1ps
module dpor_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              vertex_valid,
  input  logic [1:0]        op,
  input  logic              pixel_stall,
  input  dpor_pkg::status_t status,
  output logic              vertex_stall,
  output logic              pixel_valid,
  output dpor_pkg::cmd_t    cmd
);
  import dpor_pkg::*;

  state_t state, state_next;
  logic   has_vertex, accepting;
  logic   take, active, draw;

  always_comb begin
    take   = (state == ST_IDLE) && vertex_valid;
    active = accepting && (op == OP_ADD || op == OP_CLOSE);
    draw   = take && active && (op == OP_CLOSE || has_vertex);
  end

  always_comb begin
    vertex_stall   = (state != ST_IDLE);
    pixel_valid    = (state == ST_DRAW);
    cmd            = '0;
    cmd.load_first = take && active && !has_vertex;
    cmd.load_prev  = take && active;
    cmd.line_start = draw;
    cmd.to_first   = (op == OP_CLOSE);
    cmd.div_step   = (state == ST_DIV) && !status.len_zero && !status.div_done;
    cmd.div_finish = (state == ST_DIV) && status.div_done;
    cmd.pixel_step = (state == ST_DRAW) && !pixel_stall;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (draw) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.len_zero) state_next = ST_IDLE;
        else if (status.div_done) state_next = ST_DRAW;
      end
      ST_DRAW: begin
        if (!pixel_stall && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      has_vertex <= 1'b0;
      accepting  <= 1'b1;
    end else begin
      state <= state_next;
      if (take) begin
        if (op == OP_RESTART) begin
          has_vertex <= 1'b0;
          accepting  <= 1'b1;
        end else if (active) begin
          has_vertex <= 1'b1;
          if (op == OP_CLOSE) accepting <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/dda_polygon_outline_rasterizer_unit.sv
// Top level of the DDA polygon outline rasterizer: APB pen color register,
// controller and datapath. Depends on dpor_pkg, dpor_ctrl, dpor_datapath, assert_macros.svh.
//
//  channel  handshake                   payload
//  vertex   vertex_valid / vertex_stall op, vertex_x, vertex_y
//  pixel    pixel_valid / pixel_stall   pixel_x, pixel_y, pixel_color, last
//  config   APB psel/penable/pready     paddr, pwdata, prdata
//
// A vertex that draws a line of len pixels holds the block through the 22-step restoring
// divider and then its pixels, one pixel per cycle while pixel_stall is low.
// A zero-length line skips the divide steps; other items do not hold the block.
// rst is synchronous and restores pen color 0x646464 and an open, empty polygon.
// A stalled pixel holds its payload; the vertex side stays stalled until the line ends.
`timescale 1ns / 1ps
module dda_polygon_outline_rasterizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            vertex_valid,
  output logic                            vertex_stall,
  input  logic [1:0]                      op,
  input  logic [dpor_pkg::COORD_BITS-1:0] vertex_x,
  input  logic [dpor_pkg::COORD_BITS-1:0] vertex_y,
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [dpor_pkg::COORD_BITS-1:0] pixel_x,
  output logic [dpor_pkg::COORD_BITS-1:0] pixel_y,
  output logic [dpor_pkg::COLOR_W-1:0]    pixel_color,
  output logic                            last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import dpor_pkg::*;

  localparam logic [2:0] ADDR_PEN_COLOR = 3'd0;

  logic [COLOR_W-1:0] pen_color;
  cmd_t               cmd;
  status_t            status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_color <= 24'h646464;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_PEN_COLOR) begin
      pen_color <= pwdata[COLOR_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_PEN_COLOR) ? {{(32-COLOR_W){1'b0}}, pen_color} : '0;

  dpor_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .op           (op),
    .pixel_stall  (pixel_stall),
    .status       (status),
    .vertex_stall (vertex_stall),
    .pixel_valid  (pixel_valid),
    .cmd          (cmd)
  );

  dpor_datapath u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .status   (status),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y)
  );

  assign pixel_color = pen_color;
  assign last        = status.last;

`include "assert_macros.svh"

  `ASSERT_SAME(a_draw_blocks_input, pixel_valid, vertex_stall)
  `ASSERT_NEXT(a_divide_before_pixels, vertex_valid && !vertex_stall, !pixel_valid)
  `ASSERT_NEXT(a_last_ends_line, pixel_valid && !pixel_stall && last, !pixel_valid)
  `ASSERT_SAME(a_step_only_when_taken, cmd.pixel_step, pixel_valid && !pixel_stall)

endmodule
